// ===== rtl/core/bcad_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcad_pkg: shared types and constants of the bridge control block
// Access codes, data register indexes, decode tables and the word structs
// that pass between the register file, the decoder and the top level.
// ----------------------------------------------------------------------------
package bcad_pkg;

  typedef enum logic [1:0] {
    ACT_CTRL_READ   = 2'd0,
    ACT_CTRL_WRITE  = 2'd1,
    ACT_LATCH_READ  = 2'd2,
    ACT_LATCH_WRITE = 2'd3
  } action_e;

  // Data register indexes
  localparam logic [7:0] IDX_ID     = 8'd0;
  localparam logic [7:0] IDX_WINDOW = 8'd1;
  localparam logic [7:0] IDX_LINEAR = 8'd2;
  localparam logic [7:0] IDX_ACCESS = 8'd3;
  localparam logic [7:0] IDX_WINNUM = 8'd4;

  localparam logic [7:0] ID_BYTE          = 8'h5b;
  localparam logic [7:0] OUT_OF_RANGE     = 8'hff;
  localparam logic [7:0] WINDOW_RESET     = 8'he0;
  localparam logic [7:0] PAGE_PROBE_LOW   = 8'h00;
  localparam logic [7:0] PAGE_PROBE_HIGH  = 8'hff;
  localparam logic [3:0] ISA_PAGE_NIBBLE  = 4'ha;

  // Window select codes
  localparam logic [7:0] WIN_CODE_LOW  = 8'h10;
  localparam logic [7:0] WIN_CODE_A0   = 8'ha0;
  localparam logic [7:0] WIN_CODE_80   = 8'h80;
  localparam logic [7:0] WIN_CODE_C0   = 8'hc0;
  localparam logic [7:0] WIN_CODE_E0   = 8'he0;

  typedef struct packed {
    logic [1:0] action;
    logic       port_odd;
    logic [7:0] write_data;
    logic [7:0] seq_ext_value;
    logic [7:0] gfx_ext_value;
  } item_t;

  typedef struct packed {
    logic [7:0] window_select;
    logic [7:0] linear_page;
    logic [7:0] access_control;
    logic       video_latch;
  } ctrl_state_t;

  typedef struct packed {
    logic       linear_enable;
    logic [7:0] linear_page;
    logic       banked_enable;
    logic [7:0] banked_base_page;
    logic       isa_enable;
    logic       isa_size_two_mib;
    logic       display_relay;
  } aperture_t;

  function automatic logic [7:0] banked_page_of(logic [7:0] code);
    logic [7:0] page;
    unique case (code)
      WIN_CODE_LOW: page = 8'h0b;
      WIN_CODE_A0:  page = 8'hf0;
      WIN_CODE_80:  page = 8'hf2;
      WIN_CODE_C0:  page = 8'hf4;
      WIN_CODE_E0:  page = 8'hf6;
      default:      page = 8'h00;
    endcase
    return page;
  endfunction

  function automatic logic [7:0] window_number_of(logic [7:0] code);
    logic [7:0] num;
    unique case (code)
      WIN_CODE_80: num = 8'd1;
      WIN_CODE_C0: num = 8'd2;
      WIN_CODE_E0: num = 8'd3;
      default:     num = 8'd0;
    endcase
    return num;
  endfunction

endpackage

// ===== rtl/core/bcad_regfile.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcad_regfile: index, control registers and video enable latch
// Serves one byte access per cycle and presents the state after the access.
// ----------------------------------------------------------------------------
module bcad_regfile (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  bcad_pkg::item_t      item_i,
  output logic [7:0]           read_data_o,
  output bcad_pkg::ctrl_state_t state_next_o
);
  import bcad_pkg::*;

  logic [7:0]  index_q, index_d;
  ctrl_state_t state_q, state_d;
  logic [7:0]  data_rd;
  action_e     act;

  assign act = action_e'(item_i.action);

  always_comb begin
    unique case (index_q)
      IDX_ID:     data_rd = ID_BYTE;
      IDX_WINDOW: data_rd = state_q.window_select;
      IDX_LINEAR: data_rd = state_q.linear_page;
      IDX_ACCESS: data_rd = state_q.access_control;
      IDX_WINNUM: data_rd = window_number_of(state_q.window_select);
      default:    data_rd = OUT_OF_RANGE;
    endcase
  end

  always_comb begin
    index_d     = index_q;
    state_d     = state_q;
    read_data_o = 8'h00;
    if (valid_i) begin
      unique case (act)
        ACT_CTRL_READ: begin
          read_data_o = item_i.port_odd ? data_rd : index_q;
        end
        ACT_CTRL_WRITE: begin
          if (!item_i.port_odd) begin
            index_d = item_i.write_data;
          end else begin
            unique case (index_q)
              IDX_WINDOW: state_d.window_select = item_i.write_data;
              IDX_LINEAR: begin
                // drop the probe values, keep the last real page
                if (item_i.write_data != PAGE_PROBE_LOW &&
                    item_i.write_data != PAGE_PROBE_HIGH) begin
                  state_d.linear_page = item_i.write_data;
                end
              end
              IDX_ACCESS: state_d.access_control = item_i.write_data;
              default:    ;
            endcase
          end
        end
        ACT_LATCH_READ: begin
          read_data_o = {7'd0, state_q.video_latch};
        end
        ACT_LATCH_WRITE: begin
          state_d.video_latch = item_i.write_data[0];
        end
        default: ;
      endcase
    end
  end

  assign state_next_o = state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      index_q                <= 8'h00;
      state_q.window_select  <= WINDOW_RESET;
      state_q.linear_page    <= 8'h00;
      state_q.access_control <= 8'h00;
      state_q.video_latch    <= 1'b0;
    end else begin
      index_q <= index_d;
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/core/bcad_decode.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcad_decode: aperture and relay decode
// Turns the control state and the core's SR07/GR0B values into window enables, bases and the relay.
// ----------------------------------------------------------------------------
module bcad_decode (
  input  bcad_pkg::ctrl_state_t state_i,
  input  logic [7:0]            seq_ext_value_i,
  input  logic [7:0]            gfx_ext_value_i,
  output bcad_pkg::aperture_t   aperture_o
);
  import bcad_pkg::*;

  logic       lin;
  logic       banked;
  logic       isa;
  logic [7:0] bpage;
  logic [3:0] isa_nibble;
  logic       relay;

  assign lin    = state_i.linear_page != PAGE_PROBE_LOW &&
                  state_i.linear_page != PAGE_PROBE_HIGH;
  assign bpage  = banked_page_of(state_i.window_select);
  assign relay  = state_i.access_control[1] | state_i.video_latch;
  assign banked = !lin && ((state_i.access_control[1:0] != 2'b00) || state_i.video_latch)
                  && (bpage != 8'h00);

  // GR0B bit 5 masks SR07 bit 4 (2 MiB aperture)
  assign isa_nibble = {seq_ext_value_i[7:5], seq_ext_value_i[4] & ~gfx_ext_value_i[5]};
  assign isa        = isa_nibble == ISA_PAGE_NIBBLE;

  always_comb begin
    aperture_o.linear_enable    = lin;
    aperture_o.linear_page      = lin ? state_i.linear_page : 8'h00;
    aperture_o.banked_enable    = banked;
    aperture_o.banked_base_page = banked ? bpage : 8'h00;
    aperture_o.isa_enable       = isa;
    aperture_o.isa_size_two_mib = isa & gfx_ext_value_i[5];
    aperture_o.display_relay    = relay;
  end

endmodule

// ===== rtl/core/bridge_control_aperture_decode.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bridge_control_aperture_decode: bridge control block with aperture decode
// Byte accesses to the index/data pair and video enable latch, followed by
// decode of the linear, banked and ISA windows and the monitor relay.
// ----------------------------------------------------------------------------
//  Channel  | Handshake            | Word
//  ---------+----------------------+----------------------------------------
//  access   | start_i, busy_o      | action, port_odd, write_data, SR07, GR0B
//  result   | done_o (one cycle)   | read_data, window enables/bases, relay
//
//  One word enters per cycle; busy_o stays low. A word taken by the input
//  register passes through the access/decode logic into the result
//  register, and shows its result once the result register has loaded.
//  Reset returns the index, control registers and latch to their reset
//  values (window select 0xe0, all else zero), and kills any word in flight.
//  The receiver cannot stall: each result shows for one cycle.
// ----------------------------------------------------------------------------
module bridge_control_aperture_decode (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  output logic       busy_o,
  input  logic [1:0] action_i,
  input  logic       port_odd_i,
  input  logic [7:0] write_data_i,
  input  logic [7:0] seq_ext_value_i,
  input  logic [7:0] gfx_ext_value_i,
  output logic       done_o,
  output logic [7:0] read_data_o,
  output logic       linear_enable_o,
  output logic [7:0] linear_page_o,
  output logic       banked_enable_o,
  output logic [7:0] banked_base_page_o,
  output logic       isa_enable_o,
  output logic       isa_size_two_mib_o,
  output logic       display_relay_o
);
  import bcad_pkg::*;

  // Input register
  logic        in_valid_q;
  item_t       item_q;
  logic        accept;

  // Access and decode
  logic [7:0]  rd_data;
  ctrl_state_t state_next;
  aperture_t   aperture;

  // Result register
  logic        done_q;
  logic [7:0]  read_data_q;
  aperture_t   aperture_q;

  // The pipeline never backs up, so accept every start
  assign busy_o = 1'b0;
  assign accept = start_i & ~busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= accept;
    end
  end

  // Capture the word; payload needs no reset
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.action        <= action_i;
      item_q.port_odd      <= port_odd_i;
      item_q.write_data    <= write_data_i;
      item_q.seq_ext_value <= seq_ext_value_i;
      item_q.gfx_ext_value <= gfx_ext_value_i;
    end
  end

  // Registers update at the same edge the result loads, so the next word
  // already sees the new state
  bcad_regfile u_regfile (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (in_valid_q),
    .item_i       (item_q),
    .read_data_o  (rd_data),
    .state_next_o (state_next)
  );

  // Decode from the post-access state
  bcad_decode u_decode (
    .state_i         (state_next),
    .seq_ext_value_i (item_q.seq_ext_value),
    .gfx_ext_value_i (item_q.gfx_ext_value),
    .aperture_o      (aperture)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= in_valid_q;
    end
  end

  // Hold the result payload until the next word finishes
  always_ff @(posedge clk_i) begin
    if (in_valid_q) begin
      read_data_q <= rd_data;
      aperture_q  <= aperture;
    end
  end

  assign done_o             = done_q;
  assign read_data_o        = read_data_q;
  assign linear_enable_o    = aperture_q.linear_enable;
  assign linear_page_o      = aperture_q.linear_page;
  assign banked_enable_o    = aperture_q.banked_enable;
  assign banked_base_page_o = aperture_q.banked_base_page;
  assign isa_enable_o       = aperture_q.isa_enable;
  assign isa_size_two_mib_o = aperture_q.isa_size_two_mib;
  assign display_relay_o    = aperture_q.display_relay;

endmodule

// ===== rtl/core/bcad_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcad_checker: port-level checks of the bridge control block
// Watches latency, linear/banked exclusion, zero bases and the ISA size flag.
// ----------------------------------------------------------------------------
module bcad_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start_i,
  input logic       busy_o,
  input logic       done_o,
  input logic       linear_enable_o,
  input logic [7:0] linear_page_o,
  input logic       banked_enable_o,
  input logic [7:0] banked_base_page_o,
  input logic       isa_enable_o,
  input logic       isa_size_two_mib_o
);

  // Each result traces back to a word accepted ahead of the input and result registers
  a_done_from_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, 2))
    else $error("result without matching access");

  a_linear_excludes_banked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && linear_enable_o |-> !banked_enable_o)
    else $error("banked window decoded beside linear window");

  a_bases_zero_when_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (linear_enable_o || linear_page_o == 8'h00) &&
               (banked_enable_o || banked_base_page_o == 8'h00))
    else $error("window base set while window disabled");

  a_isa_size_needs_enable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && isa_size_two_mib_o |-> isa_enable_o)
    else $error("ISA size flag without ISA aperture");

endmodule

bind bridge_control_aperture_decode bcad_checker u_bcad_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .start_i            (start_i),
  .busy_o             (busy_o),
  .done_o             (done_o),
  .linear_enable_o    (linear_enable_o),
  .linear_page_o      (linear_page_o),
  .banked_enable_o    (banked_enable_o),
  .banked_base_page_o (banked_base_page_o),
  .isa_enable_o       (isa_enable_o),
  .isa_size_two_mib_o (isa_size_two_mib_o)
);
